### rtl/core/rfba_pkg.sv
// Shared types and constants for the run free-list block allocator.
`timescale 1ns / 1ps
`default_nettype none

package rfba_pkg;

  // Pool size and derived widths.
  localparam int NUM_BLOCKS = 64;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

  // Operation codes of an input word.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // The end-of-list link is the value NUM_BLOCKS.
  localparam logic [CNT_W-1:0] LINK_END = CNT_W'(NUM_BLOCKS);

  // One run header: length of the run and link to the next run.
  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] link;
  } hdr_t;

  // Header of the single run that covers the whole pool after reset.
  localparam hdr_t HDR_RESET = '{len: CNT_W'(NUM_BLOCKS), link: LINK_END};

  // Access request from the controller to the header memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    hdr_t             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } hdr_req_t;

endpackage

`default_nettype wire

### rtl/core/rfba_hdr_ram.sv
// Run header memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rfba_hdr_ram (
  input  wire logic              clk,
  input  wire rfba_pkg::hdr_req_t req,
  output rfba_pkg::hdr_t         rdata
);

  rfba_pkg::hdr_t mem [rfba_pkg::NUM_BLOCKS];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/run_free_list_block_allocator_top.sv
// Top level of the run free-list block allocator: controller and header memory.
//
// Usage: the block hands out and takes back fixed-size blocks of a pool of
// NUM_BLOCKS blocks. A command word (op, block_index) is taken at a rising
// edge where start is high and busy is low. Each command gives exactly one
// result word on ok and granted_index, marked by done for one cycle; the
// receiver cannot hold it off. granted_index carries the block on a
// successful allocate and is zero otherwise.
//
// Sequence: an allocate, or a free that fails, passes through the execute
// state only; a free that succeeds also passes through the link state unless
// the free list was empty. done rises in the cycle after the last working
// state, and a new command may be accepted while done is high. This comes from
// the registered read of the run header memory followed by one header write
// per cycle (a successful free into a non-empty list writes two headers).
//
// Reset (rst, synchronous) restores the initial pool: one run of all blocks
// starting at block 0 and no block taken. No clearing pass is needed; the
// block is ready as soon as reset ends.
`timescale 1ns / 1ps
`default_nettype none

module run_free_list_block_allocator_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       op,
  input  wire logic [rfba_pkg::IDX_W-1:0] block_index,
  output logic                            done,
  output logic                            ok,
  output logic [rfba_pkg::IDX_W-1:0]      granted_index
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;

  logic [1:0]                      state;
  logic [rfba_pkg::IDX_W-1:0]      head;
  logic                            nonempty;
  logic [rfba_pkg::NUM_BLOCKS-1:0] taken;
  logic                            hdr0_init;
  logic                            rd_init;
  logic                            op_q;
  logic [rfba_pkg::IDX_W-1:0]      idx_q;

  rfba_pkg::hdr_req_t              req;
  rfba_pkg::hdr_t                  ram_rdata;
  rfba_pkg::hdr_t                  hdr_cur;
  logic [rfba_pkg::CNT_W-1:0]      nxt_blk;
  logic                            split;
  logic                            link_ok;
  logic                            accept;
  logic                            to_link;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Header of the run being worked on; entry 0 reads its reset value until written.
  assign hdr_cur = rd_init ? rfba_pkg::HDR_RESET : ram_rdata;
  assign nxt_blk = {1'b0, head} + rfba_pkg::CNT_W'(1);
  assign split   = (hdr_cur.len > rfba_pkg::CNT_W'(1)) &&
                   (nxt_blk < rfba_pkg::CNT_W'(rfba_pkg::NUM_BLOCKS));
  assign link_ok = (hdr_cur.link < rfba_pkg::LINK_END);

  // A successful free into a non-empty list needs the extra link state.
  assign to_link = (op_q == rfba_pkg::OP_FREE) && taken[idx_q] && nonempty;

  // Header memory requests.
  always_comb begin
    req       = '0;
    req.re    = accept;
    req.raddr = head;
    case (state)
      S_EXEC: begin
        if (op_q == rfba_pkg::OP_ALLOC) begin
          if (nonempty && split) begin
            req.we         = 1'b1;
            req.waddr      = nxt_blk[rfba_pkg::IDX_W-1:0];
            req.wdata.len  = hdr_cur.len - rfba_pkg::CNT_W'(1);
            req.wdata.link = hdr_cur.link;
          end
        end else if (taken[idx_q]) begin
          req.we         = 1'b1;
          req.waddr      = idx_q;
          req.wdata.len  = rfba_pkg::CNT_W'(1);
          req.wdata.link = nonempty ? hdr_cur.link : rfba_pkg::LINK_END;
        end
      end
      S_LINK: begin
        req.we         = 1'b1;
        req.waddr      = head;
        req.wdata.len  = hdr_cur.len;
        req.wdata.link = {1'b0, idx_q};
      end
      default: begin
      end
    endcase
  end

  rfba_hdr_ram u_hdr_ram (
    .clk   (clk),
    .req   (req),
    .rdata (ram_rdata)
  );

  // Command payload and reset-header marker, captured with the read.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      idx_q   <= block_index;
      rd_init <= hdr0_init && (head == '0);
    end
  end

  // Sequencer, list head, taken flags and result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      nonempty      <= 1'b1;
      taken         <= '0;
      hdr0_init     <= 1'b1;
      done          <= 1'b0;
      ok            <= 1'b0;
      granted_index <= '0;
    end else begin
      if (req.we && (req.waddr == '0)) begin
        hdr0_init <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (to_link) begin
            state <= S_LINK;
            done  <= 1'b0;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
          if (op_q == rfba_pkg::OP_ALLOC) begin
            // Take the first block of the head run.
            if (nonempty) begin
              ok            <= 1'b1;
              granted_index <= head;
              taken[head]   <= 1'b1;
              if (split) begin
                head <= nxt_blk[rfba_pkg::IDX_W-1:0];
              end else if (link_ok) begin
                head <= hdr_cur.link[rfba_pkg::IDX_W-1:0];
              end else begin
                nonempty <= 1'b0;
              end
            end else begin
              ok            <= 1'b0;
              granted_index <= '0;
            end
          end else begin
            // Return a taken block as a one-block run.
            granted_index <= '0;
            if (taken[idx_q]) begin
              taken[idx_q] <= 1'b0;
              if (!nonempty) begin
                ok       <= 1'b1;
                head     <= idx_q;
                nonempty <= 1'b1;
              end
            end else begin
              ok <= 1'b0;
            end
          end
        end
        S_LINK: begin
          state <= S_IDLE;
          done  <= 1'b1;
          ok    <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/rfba_checker.sv
// Port-level checks for the allocator top level, bound to it.
`timescale 1ns / 1ps
`default_nettype none

module rfba_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       done,
  input wire logic                       ok,
  input wire logic [rfba_pkg::IDX_W-1:0] granted_index
);

  // An accepted command always keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted command");

  // No result can appear in the cycle after a command is accepted.
  a_accept_no_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result word too early after accept");

  // Results are single-cycle strobes, never back to back.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A failed command grants nothing.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (granted_index == '0))
    else $error("nonzero granted index on failure");

endmodule

bind run_free_list_block_allocator_top rfba_checker u_rfba_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .ok            (ok),
  .granted_index (granted_index)
);

`default_nettype wire

### tb/sv/tb_run_free_list_block_allocator_top.sv
// Self-checking testbench for the run free-list block allocator top level.
`timescale 1ns / 1ps

module tb_run_free_list_block_allocator_top;
  import rfba_pkg::*;

  // One result word as the allocator reports it.
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] granted;
  } grant_word_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             op;
  logic [IDX_W-1:0] block_index;
  wire              busy;
  wire              done;
  wire              ok;
  wire [IDX_W-1:0]  granted_index;

  run_free_list_block_allocator_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .block_index  (block_index),
    .done         (done),
    .ok           (ok),
    .granted_index(granted_index)
  );

  // Shadow copy of the free list, the run headers and the taken flags.
  logic [IDX_W-1:0] pool_head;
  logic             pool_nonempty;
  logic [CNT_W-1:0] pool_len [NUM_BLOCKS];
  logic [CNT_W-1:0] pool_link[NUM_BLOCKS];
  logic             pool_taken[NUM_BLOCKS];

  // Result words still owed by the allocator, oldest first.
  grant_word_t pending_grants[$];
  grant_word_t want_word;

  int errors;
  int n_grants;
  int n_alloc_fail;
  int n_frees;
  int n_free_reject;
  int n_empty_free;
  bit idle_enable;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("** run_free_list_block_allocator_top: FAILED **");
    $finish;
  end

  // Put the shadow pool back to one run covering every block.
  function automatic void reset_pool_shadow();
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      pool_len[k]   = '0;
      pool_link[k]  = '0;
      pool_taken[k] = 1'b0;
    end
    pool_head     = '0;
    pool_nonempty = 1'b1;
    pool_len[0]   = CNT_W'(NUM_BLOCKS);
    pool_link[0]  = LINK_END;
  endfunction

  // Apply one command to the shadow pool and return the word it must produce.
  function automatic grant_word_t apply_command(logic cmd, logic [IDX_W-1:0] idx);
    grant_word_t      res;
    logic [IDX_W-1:0] b;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] link;
    res = '0;
    if (cmd == OP_ALLOC) begin
      if (!pool_nonempty) begin
        n_alloc_fail++;
      end else begin
        b    = pool_head;
        len  = pool_len[b];
        link = pool_link[b];
        // Shrink the head run, or move on to the next run, or empty the list.
        if (len > 1 && int'(b) + 1 < NUM_BLOCKS) begin
          pool_len[b + 1'b1]  = len - 1'b1;
          pool_link[b + 1'b1] = link;
          pool_head           = b + 1'b1;
        end else if (int'(link) < NUM_BLOCKS) begin
          pool_head = link[IDX_W-1:0];
        end else begin
          pool_nonempty = 1'b0;
        end
        pool_taken[b] = 1'b1;
        res.ok        = 1'b1;
        res.granted   = b;
        n_grants++;
      end
    end else if (!pool_taken[idx]) begin
      n_free_reject++;
    end else begin
      // The freed block becomes a one-block run after the head, or the head.
      pool_taken[idx] = 1'b0;
      pool_len[idx]   = CNT_W'(1);
      if (pool_nonempty) begin
        pool_link[idx]       = pool_link[pool_head];
        pool_link[pool_head] = CNT_W'(idx);
      end else begin
        pool_link[idx] = LINK_END;
        pool_head      = idx;
        pool_nonempty  = 1'b1;
        n_empty_free++;
      end
      res.ok = 1'b1;
      n_frees++;
    end
    return res;
  endfunction

  // Mostly no gap, some short ones and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // A block that is currently taken, or a random one if none is.
  function automatic logic [IDX_W-1:0] pick_taken_block();
    int s;
    s = $urandom_range(0, NUM_BLOCKS - 1);
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      if (pool_taken[(s + k) % NUM_BLOCKS]) return IDX_W'((s + k) % NUM_BLOCKS);
    end
    return IDX_W'(s);
  endfunction

  // Send one command word after an optional idle gap; called at a rising edge.
  task automatic send_word(logic cmd, logic [IDX_W-1:0] idx, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        op          <= 1'($urandom);
        block_index <= IDX_W'($urandom);
        @(posedge clk);
      end
    end
    start       <= 1'b1;
    op          <= cmd;
    block_index <= idx;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_grants.push_back(apply_command(cmd, idx));
  endtask

  // Stop sending until every owed result word has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() > 0) @(posedge clk);
  endtask

  // Basic allocate and free paths, double free and free of a block never taken.
  task automatic test_basic_commands();
    send_word(OP_ALLOC, 6'd63, 0);
    send_word(OP_ALLOC, 6'd0, 0);
    send_word(OP_ALLOC, 6'd21, 1);
    send_word(OP_FREE, 6'd1, 0);
    send_word(OP_FREE, 6'd1, 0);
    send_word(OP_FREE, 6'd63, 2);
    send_word(OP_FREE, 6'd0, 0);
    send_word(OP_ALLOC, 6'd42, 0);
    send_word(OP_ALLOC, 6'd0, 0);
    send_word(OP_ALLOC, 6'd0, 0);
    send_word(OP_FREE, 6'd2, 0);
    send_word(OP_FREE, 6'd0, 0);
    wait_for_results();
  endtask

  // Drain the pool, then exercise the empty list and one-block runs.
  task automatic test_pool_exhaustion();
    while (pool_nonempty) send_word(OP_ALLOC, IDX_W'($urandom), pick_gap());
    send_word(OP_ALLOC, 6'd0, 0);
    send_word(OP_ALLOC, 6'd63, 0);
    send_word(OP_FREE, 6'd63, 0);
    send_word(OP_ALLOC, 6'd0, 0);
    send_word(OP_ALLOC, 6'd0, 0);
    send_word(OP_FREE, 6'd0, 0);
    send_word(OP_FREE, 6'd63, 0);
    send_word(OP_ALLOC, 6'd0, 0);
    send_word(OP_ALLOC, 6'd0, 0);
    send_word(OP_ALLOC, 6'd0, 0);
    wait_for_results();
  endtask

  // Random mix; most frees name a taken block, the rest are random indexes.
  task automatic test_random_mix(int n_words, int alloc_pct, int good_free_pct);
    for (int k = 0; k < n_words; k++) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_word(OP_ALLOC, IDX_W'($urandom), pick_gap());
      end else if ($urandom_range(0, 99) < good_free_pct) begin
        send_word(OP_FREE, pick_taken_block(), pick_gap());
      end else begin
        send_word(OP_FREE, IDX_W'($urandom), pick_gap());
      end
    end
  endtask

  // Check each result word against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_grants.size() == 0) begin
        $error("result word with none expected: ok=%0d granted_index=%0d",
               ok, granted_index);
        errors++;
      end else begin
        want_word = pending_grants.pop_front();
        if (ok !== want_word.ok) begin
          $error("ok: expected %0d, got %0d", want_word.ok, ok);
          errors++;
        end
        if (granted_index !== want_word.granted) begin
          $error("granted_index: expected %0d, got %0d", want_word.granted,
                 granted_index);
          errors++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    int waited;
    errors        = 0;
    n_grants      = 0;
    n_alloc_fail  = 0;
    n_frees       = 0;
    n_free_reject = 0;
    n_empty_free  = 0;
    idle_enable   = 1'b1;
    rst           = 1'b1;
    start         = 1'b0;
    op            = OP_ALLOC;
    block_index   = '0;
    reset_pool_shadow();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_basic_commands();
    test_pool_exhaustion();
    test_random_mix(325, 75, 90);
    wait_for_results();
    test_random_mix(325, 30, 85);
    // A stretch with no idle cycles at all.
    idle_enable = 1'b0;
    test_random_mix(325, 50, 90);
    idle_enable = 1'b1;
    wait_for_results();
    test_random_mix(275, 60, 80);

    // Let the last words come back.
    start  <= 1'b0;
    waited = 0;
    while (pending_grants.size() > 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_grants.size() > 0) begin
      $error("%0d result words never arrived", pending_grants.size());
      errors++;
    end

    $display("Covered %0d grants, %0d allocates on an empty pool, %0d frees",
             n_grants, n_alloc_fail, n_frees);
    $display("(%0d into an empty list) and %0d rejected frees.",
             n_empty_free, n_free_reject);
    if (errors == 0) begin
      $display("** run_free_list_block_allocator_top: PASSED **");
    end else begin
      $display("** run_free_list_block_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/rfba_pkg.sv
rtl/core/rfba_hdr_ram.sv
rtl/core/run_free_list_block_allocator_top.sv
rtl/core/rfba_checker.sv
tb/sv/tb_run_free_list_block_allocator_top.sv
